// ===== rtl/core/scan_min_distance_target_search_macros.svh =====
// Assertion macros for the scan min-distance target search block.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef SCAN_MIN_DISTANCE_TARGET_SEARCH_MACROS_SVH
`define SCAN_MIN_DISTANCE_TARGET_SEARCH_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define SMDTS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("smdts assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define SMDTS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("smdts assertion failed");

`endif

// ===== rtl/core/smdts_pkg.sv =====
// Package for the scan min-distance target search block.
// Types, register indexes and fixed constants; no dependencies.
package smdts_pkg;

    localparam int ANG_W   = 17;
    localparam int DIST_W  = 16;
    localparam int STEP_W  = 12;
    localparam int LAYER_W = 4;
    localparam int DEAD_W  = 10;
    localparam int IDX_W   = 3;

    // Wide working width for angle sums before saturation
    localparam int WIDE_W  = ANG_W + 2;

    typedef enum logic [1:0] {
        ST_CONVERGING = 2'd0,
        ST_NO_TARGET  = 2'd1,
        ST_READY      = 2'd2,
        ST_FAULT      = 2'd3
    } t_status;

    localparam logic [IDX_W-1:0] CFG_WIN_MIN    = 3'd0;
    localparam logic [IDX_W-1:0] CFG_WIN_MAX    = 3'd1;
    localparam logic [IDX_W-1:0] CFG_DIST_MIN   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_DIST_MAX   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_STEP_INIT  = 3'd4;
    localparam logic [IDX_W-1:0] CFG_LAYER_INIT = 3'd5;
    localparam logic [IDX_W-1:0] CFG_DEAD_BAND  = 3'd6;

    localparam logic signed [ANG_W-1:0] RST_WIN_MIN    = -17'sd3000;
    localparam logic signed [ANG_W-1:0] RST_WIN_MAX    = 17'sd3000;
    localparam logic [DIST_W-1:0]       RST_DIST_MIN   = 16'd0;
    localparam logic [DIST_W-1:0]       RST_DIST_MAX   = 16'd65534;
    localparam logic [STEP_W-1:0]       RST_STEP_INIT  = 12'd50;
    localparam logic [LAYER_W-1:0]      RST_LAYER_INIT = 4'd3;
    localparam logic [DEAD_W-1:0]       RST_DEAD_BAND  = 10'd20;

    localparam logic [DIST_W-1:0] NO_DIST = 16'hFFFF;

    localparam logic signed [WIDE_W-1:0] ANG_MIN_W = -19'sd65536;
    localparam logic signed [WIDE_W-1:0] ANG_MAX_W = 19'sd65535;

    // floor(2*s/3) == (s * DIV3_MUL) >> DIV3_SHIFT for any 12-bit s
    localparam logic [15:0] DIV3_MUL   = 16'd43691;
    localparam int          DIV3_SHIFT = 16;

    function automatic logic signed [ANG_W-1:0] sat_ang(input logic signed [WIDE_W-1:0] x);
        logic signed [ANG_W-1:0] res;
        if (x < ANG_MIN_W) begin
            res = ANG_MIN_W[ANG_W-1:0];
        end else if (x > ANG_MAX_W) begin
            res = ANG_MAX_W[ANG_W-1:0];
        end else begin
            res = x[ANG_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/scan_min_distance_target_search.sv =====
// Top level of the scan min-distance target search block.
// Depends on smdts_pkg and scan_min_distance_target_search_macros.svh.
//
// Layered minimum-distance search over a yaw window. Every input beat is one
// sensor sample (measured angle, laser range, restart flag) and yields exactly
// one output beat: commanded angle, status, best angle and best distance.
// While approaching, the command moves EDGE_STEP toward the nearer window
// edge; then the block sweeps in the working step, tracks the smallest range
// inside [dist_accept_min, dist_accept_max], and at the far edge either
// latches no-target / ready or narrows the window to half width around the
// best angle with a step of two thirds. A fault status latches if the approach
// stops near neither edge. Statuses other than converging hold until a beat
// with restart set, which reloads window, step and layers from the config
// registers first. Throughput is one beat per clock while the result stream
// does not stall; a beat passes the input register, then the result register.
// The search state is updated combinationally from the input register and is
// registered together with the result. The config port is ready whenever
// reset is released and must only be written while no beat is in flight.
module scan_min_distance_target_search #(
    parameter int EDGE_STEP = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    // sample stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // [16:0] measured_angle, [32:17] laser_range, pad
    input  logic [0:0]  s_axis_tuser,  // [0] restart
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // [16:0] command_angle, [33:17] found_angle,
                                       // [49:34] found_distance, pad
    output logic [1:0]  m_axis_tuser   // [1:0] search_status
);

`include "scan_min_distance_target_search_macros.svh"

    localparam int AW = smdts_pkg::ANG_W;
    localparam int DW = smdts_pkg::DIST_W;
    localparam int SW = smdts_pkg::STEP_W;
    localparam int LW = smdts_pkg::LAYER_W;
    localparam int BW = smdts_pkg::DEAD_W;
    localparam int WW = smdts_pkg::WIDE_W;

    localparam logic signed [WW-1:0] EDGE_STEP_W = WW'(EDGE_STEP);

    // ---------------- config registers ----------------
    logic signed [AW-1:0] r_cfg_wmin, r_cfg_wmax;
    logic [DW-1:0]        r_cfg_dmin, r_cfg_dmax;
    logic [SW-1:0]        r_cfg_step;
    logic [LW-1:0]        r_cfg_layers;
    logic [BW-1:0]        r_cfg_dead;

    // writes are dropped during reset, so ready follows reset
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_wmin   <= smdts_pkg::RST_WIN_MIN;
            r_cfg_wmax   <= smdts_pkg::RST_WIN_MAX;
            r_cfg_dmin   <= smdts_pkg::RST_DIST_MIN;
            r_cfg_dmax   <= smdts_pkg::RST_DIST_MAX;
            r_cfg_step   <= smdts_pkg::RST_STEP_INIT;
            r_cfg_layers <= smdts_pkg::RST_LAYER_INIT;
            r_cfg_dead   <= smdts_pkg::RST_DEAD_BAND;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                smdts_pkg::CFG_WIN_MIN:    r_cfg_wmin   <= i_cfg_data;
                smdts_pkg::CFG_WIN_MAX:    r_cfg_wmax   <= i_cfg_data;
                smdts_pkg::CFG_DIST_MIN:   r_cfg_dmin   <= i_cfg_data[DW-1:0];
                smdts_pkg::CFG_DIST_MAX:   r_cfg_dmax   <= i_cfg_data[DW-1:0];
                smdts_pkg::CFG_STEP_INIT:  r_cfg_step   <= i_cfg_data[SW-1:0];
                smdts_pkg::CFG_LAYER_INIT: r_cfg_layers <= i_cfg_data[LW-1:0];
                smdts_pkg::CFG_DEAD_BAND:  r_cfg_dead   <= i_cfg_data[BW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    logic r_in_vld, r_out_vld;
    logic adv;   // input register moves into result register this cycle

    assign adv           = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = i_rst_n && (!r_in_vld || adv);

    // ---------------- input register ----------------
    logic signed [AW-1:0] r_in_ang;
    logic [DW-1:0]        r_in_rng;
    logic                 r_in_restart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_ang     <= s_axis_tdata[AW-1:0];
            r_in_rng     <= s_axis_tdata[AW+DW-1:AW];
            r_in_restart <= s_axis_tuser[0];
        end
    end

    // ---------------- search state ----------------
    logic signed [AW-1:0] r_win_low, r_win_high, r_best_ang, r_cmd_ang;
    logic [SW-1:0]        r_step_now;
    logic [LW-1:0]        r_layers_left;
    logic                 r_sweeping, r_sweep_dir;
    logic [DW-1:0]        r_best_dist;
    smdts_pkg::t_status   r_status;

    logic signed [AW-1:0] n_win_low, n_win_high, n_best_ang, n_cmd_ang;
    logic [SW-1:0]        n_step_now;
    logic [LW-1:0]        n_layers_left;
    logic                 n_sweeping, n_sweep_dir;
    logic [DW-1:0]        n_best_dist;
    smdts_pkg::t_status   n_status;

    // working copies after an optional restart reload
    logic signed [AW-1:0] e_lo, e_hi;
    logic [SW-1:0]        e_step;
    logic signed [WW-1:0] a_w, lo_w, hi_w, d_w, sum_w, a2_w;
    logic                 go_up, go_dn, near_lo, near_hi;
    logic                 in_range;
    logic signed [AW:0]   span;      // hi - lo
    logic signed [AW:0]   quarter;   // floor(span / 4)
    logic [SW+15:0]       step_prod;
    logic [SW-1:0]        step_23;

    always_comb begin
        // reload on restart; cmd_ang is not part of the reload
        if (r_in_restart) begin
            e_lo          = r_cfg_wmin;
            e_hi          = r_cfg_wmax;
            e_step        = (r_cfg_step == '0) ? SW'(1) : r_cfg_step;
            n_layers_left = r_cfg_layers;
            n_sweeping    = 1'b0;
            n_sweep_dir   = 1'b0;
            n_best_dist   = smdts_pkg::NO_DIST;
            n_best_ang    = '0;
            n_status      = smdts_pkg::ST_CONVERGING;
        end else begin
            e_lo          = r_win_low;
            e_hi          = r_win_high;
            e_step        = r_step_now;
            n_layers_left = r_layers_left;
            n_sweeping    = r_sweeping;
            n_sweep_dir   = r_sweep_dir;
            n_best_dist   = r_best_dist;
            n_best_ang    = r_best_ang;
            n_status      = r_status;
        end
        n_win_low  = e_lo;
        n_win_high = e_hi;
        n_step_now = e_step;
        n_cmd_ang  = r_cmd_ang;

        a_w   = WW'(r_in_ang);
        lo_w  = WW'(e_lo);
        hi_w  = WW'(e_hi);
        d_w   = WW'(signed'({1'b0, r_cfg_dead}));
        sum_w = lo_w + hi_w;
        a2_w  = a_w <<< 1;

        go_up   = (a_w < lo_w - d_w) || ((a2_w >= sum_w) && (a_w < hi_w - d_w));
        go_dn   = (a_w > hi_w + d_w) || ((a2_w < sum_w) && (a_w > lo_w + d_w));
        near_lo = (a_w >= lo_w - d_w) && (a_w <= lo_w + d_w);
        near_hi = (a_w >= hi_w - d_w) && (a_w <= hi_w + d_w);

        in_range = (r_in_rng >= r_cfg_dmin) && (r_in_rng <= r_cfg_dmax);

        span      = (AW+1)'(e_hi) - (AW+1)'(e_lo);
        quarter   = span >>> 2;
        step_prod = (SW+16)'(e_step) * (SW+16)'(smdts_pkg::DIV3_MUL);
        step_23   = step_prod[SW+smdts_pkg::DIV3_SHIFT-1:smdts_pkg::DIV3_SHIFT];

        if (n_status == smdts_pkg::ST_CONVERGING) begin
            if (!n_sweeping) begin
                // approach toward the nearer edge
                if (go_up) begin
                    n_cmd_ang = smdts_pkg::sat_ang(a_w + EDGE_STEP_W);
                end else if (go_dn) begin
                    n_cmd_ang = smdts_pkg::sat_ang(a_w - EDGE_STEP_W);
                end else if (near_lo || near_hi) begin
                    n_sweep_dir = !near_lo;
                    n_sweeping  = 1'b1;
                    n_best_dist = smdts_pkg::NO_DIST;
                end else begin
                    n_status = smdts_pkg::ST_FAULT;
                end
            end else begin
                if (in_range && (r_in_rng < n_best_dist)) begin
                    n_best_dist = r_in_rng;
                    n_best_ang  = r_in_ang;
                end
                if (!n_sweep_dir && (a_w < hi_w - d_w)) begin
                    n_cmd_ang = smdts_pkg::sat_ang(a_w + WW'(signed'({1'b0, e_step})));
                end else if (n_sweep_dir && (a_w > lo_w + d_w)) begin
                    n_cmd_ang = smdts_pkg::sat_ang(a_w - WW'(signed'({1'b0, e_step})));
                end else if (n_best_dist == smdts_pkg::NO_DIST) begin
                    n_status = smdts_pkg::ST_NO_TARGET;
                end else if (n_layers_left == '0) begin
                    n_status = smdts_pkg::ST_READY;
                end else begin
                    // narrow: half-width window around best, step * 2/3
                    n_layers_left = n_layers_left - LW'(1);
                    n_step_now    = (step_23 == '0) ? SW'(1) : step_23;
                    n_win_high    = smdts_pkg::sat_ang(WW'(n_best_ang) + WW'(quarter));
                    n_win_low     = smdts_pkg::sat_ang(WW'(n_best_ang) - WW'(quarter));
                    n_sweeping    = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_low     <= smdts_pkg::RST_WIN_MIN;
            r_win_high    <= smdts_pkg::RST_WIN_MAX;
            r_step_now    <= smdts_pkg::RST_STEP_INIT;
            r_layers_left <= smdts_pkg::RST_LAYER_INIT;
            r_sweeping    <= 1'b0;
            r_sweep_dir   <= 1'b0;
            r_best_dist   <= smdts_pkg::NO_DIST;
            r_best_ang    <= '0;
            r_cmd_ang     <= '0;
            r_status      <= smdts_pkg::ST_CONVERGING;
        end else if (adv) begin
            r_win_low     <= n_win_low;
            r_win_high    <= n_win_high;
            r_step_now    <= n_step_now;
            r_layers_left <= n_layers_left;
            r_sweeping    <= n_sweeping;
            r_sweep_dir   <= n_sweep_dir;
            r_best_dist   <= n_best_dist;
            r_best_ang    <= n_best_ang;
            r_cmd_ang     <= n_cmd_ang;
            r_status      <= n_status;
        end
    end

    // ---------------- result register ----------------
    logic signed [AW-1:0] r_out_cmd, r_out_best_ang;
    logic [DW-1:0]        r_out_best_dist;
    smdts_pkg::t_status   r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_cmd       <= n_cmd_ang;
            r_out_best_ang  <= n_best_ang;
            r_out_best_dist <= n_best_dist;
            r_out_status    <= n_status;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'b0, r_out_best_dist, r_out_best_ang, r_out_cmd};
    assign m_axis_tuser  = r_out_status;

    // ---------------- assertions ----------------
    `SMDTS_ASSERT_IMP(a_step_nonzero, i_clk, i_rst_n, 1'b1, r_step_now != '0)
    `SMDTS_ASSERT_IMP(a_ready_has_dist, i_clk, i_rst_n,
        r_out_vld && (r_out_status == smdts_pkg::ST_READY),
        r_out_best_dist != smdts_pkg::NO_DIST)
    `SMDTS_ASSERT_IMP(a_notgt_no_dist, i_clk, i_rst_n,
        r_out_vld && (r_out_status == smdts_pkg::ST_NO_TARGET),
        r_out_best_dist == smdts_pkg::NO_DIST)
    `SMDTS_ASSERT_NXT(a_status_latched, i_clk, i_rst_n,
        adv && !r_in_restart && (r_status != smdts_pkg::ST_CONVERGING),
        (r_status == $past(r_status)) && (r_cmd_ang == $past(r_cmd_ang)))

endmodule
